FILE: sv/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 16;
    localparam int DATA_W        = 32;
    localparam int FILL_W        = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // per-cell control, built by the top level each cycle
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic occupied;
        logic at_tail;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/spq_cell.sv
`default_nettype none
module spq_cell (
    input  wire                  clk,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  spq_pkg::entry_t      new_entry,
    input  spq_pkg::entry_t      left_entry,
    input  wire                  left_gt,
    input  spq_pkg::entry_t      right_entry,
    output spq_pkg::entry_t      entry,
    output logic                 gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   take_new;
    logic   take_left;

    // held entry sorts after the incoming one
    assign gt        = ctrl.occupied && (entry_reg.prio > new_entry.prio);
    assign take_left = ctrl.do_insert && left_gt;
    assign take_new  = ctrl.do_insert && (gt || ctrl.at_tail) && !left_gt;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_remove)
        begin
            entry_next = right_entry;
        end
        else if (take_left)
        begin
            entry_next = left_entry;
        end
        else if (take_new)
        begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// A result word appears on the result ports in the cycle after start is taken.
// Throughput: one word per cycle; busy is never raised, every cell compares and
// shifts in the same cycle against the broadcast priority.
// Reset: rst_n clears the fill count and the done strobe; cell contents are left
// as they are and are only read below the fill count. The receiver cannot stall.
`default_nettype none
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               kind,
    input  wire  [spq_pkg::PRIO_W-1:0]        priority_req,
    input  wire  signed [spq_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [spq_pkg::PRIO_W-1:0]        out_priority,
    output logic signed [spq_pkg::DATA_W-1:0] out_value,
    output logic [spq_pkg::FILL_W-1:0]        fill
);
    import spq_pkg::*;

    // count must hold DEPTH itself
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [PRIO_W-1:0]    out_prio_reg;
    logic [PRIO_W-1:0]    out_prio_next;
    logic [DATA_W-1:0]    out_data_reg;
    logic [DATA_W-1:0]    out_data_next;
    logic [FILL_W-1:0]    fill_reg;

    logic                 accept;
    logic                 is_remove;
    logic                 ins_ok;
    logic                 rem_ok;
    logic                 full;
    logic                 empty;
    entry_t               new_entry;
    entry_t               cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_gt;

    // the whole row settles combinationally, so a new word may come every cycle
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_remove = (kind == KIND_REMOVE);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ins_ok    = accept && !is_remove && !full;
    assign rem_ok    = accept && is_remove && !empty;

    assign new_entry.prio = priority_req;
    assign new_entry.data = $unsigned(value);

    // row of cells: cell 0 is the head, cells at or beyond the count hold nothing
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            entry_t     left_e;
            logic       left_g;
            entry_t     right_e;

            assign ctrl.do_insert = ins_ok;
            assign ctrl.do_remove = rem_ok;
            assign ctrl.occupied  = (count_reg > CW'(gi));
            assign ctrl.at_tail   = (count_reg == CW'(gi));

            if (gi == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_g = cell_gt[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                // last cell keeps its stale word on a remove; it is beyond the count
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    // status, removed word and next count
    always_comb
    begin
        count_next    = count_reg;
        status_next   = ST_INSERTED;
        out_prio_next = '0;
        out_data_next = '0;
        case (is_remove)
            1'b0:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CW'(1);
                end
            end
            1'b1:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next   = ST_REMOVED;
                    out_prio_next = cell_entry[0].prio;
                    out_data_next = cell_entry[0].data;
                    count_next    = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = ST_INSERTED;
            end
        endcase
        if (!accept)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result word: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            out_prio_reg <= out_prio_next;
            out_data_reg <= out_data_next;
            fill_reg     <= FILL_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = out_prio_reg;
    assign out_value    = $signed(out_data_reg);
    assign fill         = fill_reg;

    // count never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // every accepted word gives one strobe in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted word gave no result");

    // a refused insert leaves the count at the depth
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_remove && full) |=> (count_reg == CW'(DEPTH)))
        else $error("refused insert changed the count");

    // a remove on an empty queue leaves it empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_remove && empty) |=> (count_reg == '0))
        else $error("remove on empty queue changed the count");

endmodule
`default_nettype wire
